/* rtl/ctl_pkg.sv */
// Shared types, token codes, character codes and keyword table of the C token lexer.
package ctl_pkg;

  localparam int unsigned KeywordBytes = 8;
  localparam int unsigned LengthBits   = 16;
  localparam int unsigned KwTextBytes  = 8;
  localparam int unsigned KwCount      = 34;
  localparam int unsigned QueueDepth   = 4;

  localparam logic [3:0] TokKeyword  = 4'd0;
  localparam logic [3:0] TokIdent    = 4'd1;
  localparam logic [3:0] TokInteger  = 4'd2;
  localparam logic [3:0] TokOperator = 4'd3;
  localparam logic [3:0] TokParenL   = 4'd4;
  localparam logic [3:0] TokParenR   = 4'd5;
  localparam logic [3:0] TokBraceL   = 4'd6;
  localparam logic [3:0] TokBraceR   = 4'd7;
  localparam logic [3:0] TokBrackL   = 4'd8;
  localparam logic [3:0] TokBrackR   = 4'd9;
  localparam logic [3:0] TokComma    = 4'd10;
  localparam logic [3:0] TokSemi     = 4'd11;
  localparam logic [3:0] TokString   = 4'd12;
  localparam logic [3:0] TokInvalid  = 4'd13;
  localparam logic [3:0] TokEnd      = 4'd14;

  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChUnder  = 8'h5F;
  localparam logic [7:0] ChEquals = 8'h3D;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [5:0]  keyword_number;
    logic [15:0] token_length;
    logic [7:0]  lead_byte;
    logic        has_equals;
    logic [23:0] line_number;
    logic [15:0] column_number;
    logic        last_of_run;
  } out_t;

  // Tokens produced by one request, in order.
  typedef struct packed {
    logic [1:0] count;
    out_t       first;
    out_t       second;
  } scan_out_t;

  // Keyword text as a right-justified string literal.
  function automatic logic [63:0] kw_text(int unsigned k);
    logic [63:0] t;
    case (k)
      0:  t = 64'("auto");
      1:  t = 64'("break");
      2:  t = 64'("case");
      3:  t = 64'("char");
      4:  t = 64'("const");
      5:  t = 64'("continue");
      6:  t = 64'("default");
      7:  t = 64'("do");
      8:  t = 64'("double");
      9:  t = 64'("else");
      10: t = 64'("enum");
      11: t = 64'("extern");
      12: t = 64'("float");
      13: t = 64'("for");
      14: t = 64'("goto");
      15: t = 64'("if");
      16: t = 64'("inline");
      17: t = 64'("int");
      18: t = 64'("long");
      19: t = 64'("register");
      20: t = 64'("restrict");
      21: t = 64'("return");
      22: t = 64'("short");
      23: t = 64'("signed");
      24: t = 64'("sizeof");
      25: t = 64'("static");
      26: t = 64'("struct");
      27: t = 64'("switch");
      28: t = 64'("typedef");
      29: t = 64'("union");
      30: t = 64'("unsigned");
      31: t = 64'("void");
      32: t = 64'("volatile");
      33: t = 64'("while");
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] kw_length(int unsigned k);
    logic [63:0] t;
    logic [3:0]  n;
    t = kw_text(k);
    n = '0;
    for (int j = 0; j < KwTextBytes; j++) begin
      if (t[8*j +: 8] != 8'd0) n = n + 4'd1;
    end
    return n;
  endfunction

  // Keyword laid out as the scan window holds it: first character in the low byte.
  function automatic logic [63:0] kw_pattern(int unsigned k);
    logic [63:0] t;
    logic [63:0] p;
    int unsigned n;
    t = kw_text(k);
    n = int'(kw_length(k));
    p = '0;
    for (int j = 0; j < KwTextBytes; j++) begin
      if (j < n) p[8*j +: 8] = t[8*(n-1-j) +: 8];
    end
    return p;
  endfunction

endpackage

/* rtl/c_token_lexer.sv */
// Top level of the C token lexer: scanner plus result queue.
// Tokens are registered in the result queue by the byte that completes them; its head drives the output.
// Throughput: one source byte per cycle while in_stall_o is low; the scanner registers its new state per byte.
// A byte that finishes two tokens yields two output records; a four-entry result
// queue absorbs this and raises in_stall_o when fewer than two entries are free.
// Reset (asynchronous, active low): scanner idle at line 1, column 1; queue empty.
module c_token_lexer import ctl_pkg::*; #(
  parameter int unsigned KEYWORD_BYTES = KeywordBytes,
  parameter int unsigned LENGTH_BITS   = LengthBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned CntBits = $clog2(QueueDepth + 1);

  scan_out_t          res;
  logic               accept;
  logic               pop;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [CntBits-1:0] base;
  out_t               q_q [QueueDepth];
  out_t               q_d [QueueDepth];

  assign accept = in_valid_i && !in_stall_o;
  assign pop    = (cnt_q != '0) && !out_stall_i;

  ctl_scan #(
    .KEYWORD_BYTES(KEYWORD_BYTES),
    .LENGTH_BITS  (LENGTH_BITS)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .item_i  (in_data_i),
    .res_o   (res)
  );

  // Entries shift toward the head on a pop; new tokens land behind the survivors.
  always_comb begin
    base  = pop ? cnt_q - CntBits'(1) : cnt_q;
    cnt_d = base + CntBits'(res.count);
    for (int i = 0; i < QueueDepth; i++) begin
      q_d[i] = q_q[i];
    end
    if (pop) begin
      for (int i = 0; i < QueueDepth - 1; i++) begin
        q_d[i] = q_q[i+1];
      end
    end
    for (int i = 0; i < QueueDepth; i++) begin
      if (res.count != 2'd0 && CntBits'(i) == base) q_d[i] = res.first;
      if (res.count == 2'd2 && CntBits'(i) == base + CntBits'(1)) q_d[i] = res.second;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign in_stall_o  = cnt_q > CntBits'(QueueDepth - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = q_q[0];

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntBits'(QueueDepth))
    else $error("result queue overflow");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.count == 2'd2 |-> (!res.first.last_of_run && res.second.last_of_run))
    else $error("token pair marks the wrong record as last");

  a_end_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.end_of_input) |=> out_valid_o)
    else $error("end of input produced no token");
`endif

endmodule

/* rtl/ctl_scan.sv */
// Scanner state and per-byte token recognition of the C token lexer.
module ctl_scan import ctl_pkg::*; #(
  parameter int unsigned KEYWORD_BYTES = KeywordBytes,
  parameter int unsigned LENGTH_BITS   = LengthBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  in_t       item_i,
  output scan_out_t res_o
);

  localparam int unsigned WinBits = KEYWORD_BYTES * 8;
  localparam int unsigned LenExt  = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

  typedef enum logic [3:0] {
    ModeIdle, ModeIdent, ModeInt, ModeOp, ModeSlash,
    ModeLine, ModeBlock, ModeStar, ModeString
  } mode_e;

  typedef struct packed {
    logic [23:0] line;
    logic [15:0] col;
  } pos_t;

  mode_e                  mode_q, mode_d;
  logic [WinBits-1:0]     win_q, win_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [7:0]             lead_q, lead_d;
  pos_t                   pos_q, pos_d;

  logic [7:0]  b;
  pos_t        step_p;
  logic [5:0]  kw_num;
  logic        upper_zero;
  logic [15:0] len16;
  logic [LenExt-1:0] len_ext;

  // Outcome of treating the byte as the start of a new token.
  mode_e                  i_mode;
  logic [WinBits-1:0]     i_win;
  logic [LENGTH_BITS-1:0] i_len;
  logic [7:0]             i_lead;
  logic                   i_emit;
  out_t                   i_rec;

  logic flush_ok;
  out_t flush_rec;
  logic fv, mv;
  out_t frec, mrec;

  function automatic logic is_space(logic [7:0] c);
    return c inside {8'd32, [8'd9:8'd13]};
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == ChUnder);
  endfunction

  function automatic pos_t step_pos(pos_t p, logic [7:0] c);
    pos_t r;
    r = p;
    if (c == ChLf) begin
      if (p.line != '1) r.line = p.line + 24'd1;
      r.col = 16'd1;
    end else if (p.col != '1) begin
      r.col = p.col + 16'd1;
    end
    return r;
  endfunction

  function automatic logic [3:0] punct_kind(logic [7:0] c);
    logic [3:0] k;
    case (c)
      "(":     k = TokParenL;
      ")":     k = TokParenR;
      "{":     k = TokBraceL;
      "}":     k = TokBraceR;
      "[":     k = TokBrackL;
      "]":     k = TokBrackR;
      ",":     k = TokComma;
      ";":     k = TokSemi;
      default: k = TokInvalid;
    endcase
    return k;
  endfunction

  function automatic out_t mk(logic [3:0] k, logic [5:0] kw, logic [15:0] n,
                              logic [7:0] ld, logic eq, logic [23:0] line,
                              logic [15:0] col);
    out_t r;
    r.token_kind     = k;
    r.keyword_number = kw;
    r.token_length   = n;
    r.lead_byte      = ld;
    r.has_equals     = eq;
    r.line_number    = line;
    r.column_number  = col;
    r.last_of_run    = 1'b0;
    return r;
  endfunction

  assign b      = item_i.source_byte;
  assign step_p = step_pos(pos_q, b);

  assign len_ext = LenExt'(len_q);
  assign len16   = (len_ext > LenExt'(16'hFFFF)) ? 16'hFFFF : len_ext[15:0];

  // Window bytes past the first eight are zero whenever a keyword could match.
  always_comb begin
    upper_zero = 1'b1;
    for (int i = KwTextBytes; i < KEYWORD_BYTES; i++) begin
      if (win_q[8*i +: 8] != 8'd0) upper_zero = 1'b0;
    end
  end

  always_comb begin
    kw_num = '0;
    for (int k = 0; k < KwCount; k++) begin
      if (upper_zero && win_q[63:0] == kw_pattern(k)
          && len_q == LENGTH_BITS'(kw_length(k))) begin
        kw_num = 6'(k + 1);
      end
    end
  end

  always_comb begin
    flush_ok  = 1'b1;
    flush_rec = '0;
    case (mode_q)
      ModeIdent: flush_rec = mk((kw_num != '0) ? TokKeyword : TokIdent, kw_num, len16,
                                lead_q, 1'b0, pos_q.line, pos_q.col);
      ModeInt:   flush_rec = mk(TokInteger, 6'd0, len16, lead_q, 1'b0,
                                pos_q.line, pos_q.col);
      ModeOp, ModeSlash:
                 flush_rec = mk(TokOperator, 6'd0, 16'd1, lead_q, 1'b0,
                                pos_q.line, pos_q.col);
      default:   flush_ok = 1'b0;
    endcase
  end

  always_comb begin
    i_mode = ModeIdle;
    i_win  = win_q;
    i_len  = len_q;
    i_lead = lead_q;
    i_emit = 1'b0;
    i_rec  = '0;
    if (is_space(b)) begin
      i_mode = ModeIdle;
    end else if (b == ChSlash) begin
      i_mode = ModeSlash;
      i_win  = '0;
      i_len  = '0;
      i_lead = b;
    end else if (is_alpha(b) || b == ChUnder || is_digit(b)) begin
      i_mode = is_digit(b) ? ModeInt : ModeIdent;
      i_win  = WinBits'(b);
      i_len  = LENGTH_BITS'(1);
      i_lead = b;
    end else if (b inside {"+", "-", "*", "="}) begin
      i_mode = ModeOp;
      i_win  = '0;
      i_len  = '0;
      i_lead = b;
    end else if (b inside {">", "<", "!", "&", "|"}) begin
      i_emit = 1'b1;
      i_rec  = mk(TokOperator, 6'd0, 16'd1, b, 1'b0, step_p.line, step_p.col);
    end else if (b == ChQuote) begin
      i_mode = ModeString;
      i_win  = '0;
      i_len  = '0;
      i_lead = 8'd0;
    end else begin
      // Punctuation and invalid bytes report the column they started at.
      i_emit = 1'b1;
      i_rec  = mk(punct_kind(b), 6'd0, 16'd1, b, 1'b0, step_p.line, pos_q.col);
    end
  end

  always_comb begin
    mode_d = mode_q;
    win_d  = win_q;
    len_d  = len_q;
    lead_d = lead_q;
    pos_d  = pos_q;
    fv     = 1'b0;
    mv     = 1'b0;
    frec   = flush_rec;
    mrec   = '0;
    if (accept_i) begin
      if (item_i.end_of_input) begin
        if (mode_q == ModeString) begin
          fv   = 1'b1;
          frec = mk(TokInvalid, 6'd0, len16, lead_q, 1'b0, pos_q.line, pos_q.col);
        end else begin
          fv = flush_ok;
        end
        mv     = 1'b1;
        mrec   = mk(TokEnd, 6'd0, 16'd0, 8'd0, 1'b0, pos_q.line, pos_q.col);
        mode_d = ModeIdle;
        win_d  = '0;
        len_d  = '0;
        lead_d = '0;
        pos_d  = '{line: 24'd1, col: 16'd1};
      end else begin
        case (mode_q)
          ModeIdent, ModeInt: begin
            if ((mode_q == ModeIdent) ? is_word(b) : is_digit(b)) begin
              for (int i = 0; i < KEYWORD_BYTES; i++) begin
                if (len_q == LENGTH_BITS'(i)) win_d[8*i +: 8] = b;
              end
              if (len_q != '1) len_d = len_q + LENGTH_BITS'(1);
              pos_d = step_p;
            end else begin
              fv     = 1'b1;
              mode_d = i_mode;
              win_d  = i_win;
              len_d  = i_len;
              lead_d = i_lead;
              pos_d  = step_p;
              mv     = i_emit;
              mrec   = i_rec;
            end
          end
          ModeOp, ModeSlash: begin
            if (b == ChEquals) begin
              mv     = 1'b1;
              mrec   = mk(TokOperator, 6'd0, 16'd2, lead_q, 1'b1, step_p.line, step_p.col);
              mode_d = ModeIdle;
              pos_d  = step_p;
            end else if (mode_q == ModeSlash && b == ChSlash) begin
              mode_d = ModeLine;
              pos_d  = step_p;
            end else if (mode_q == ModeSlash && b == ChStar) begin
              mode_d = ModeBlock;
              pos_d  = step_p;
            end else begin
              fv     = 1'b1;
              mode_d = i_mode;
              win_d  = i_win;
              len_d  = i_len;
              lead_d = i_lead;
              pos_d  = step_p;
              mv     = i_emit;
              mrec   = i_rec;
            end
          end
          ModeLine: begin
            if (b == ChLf) mode_d = ModeIdle;
            pos_d = step_p;
          end
          ModeBlock: begin
            if (b == ChStar) mode_d = ModeStar;
            pos_d = step_p;
          end
          ModeStar: begin
            if (b == ChSlash) begin
              mode_d = ModeIdle;
            end else if (b != ChStar) begin
              mode_d = ModeBlock;
            end
            pos_d = step_p;
          end
          ModeString: begin
            pos_d = step_p;
            if (b == ChQuote) begin
              mv     = 1'b1;
              mrec   = mk(TokString, 6'd0, len16, lead_q, 1'b0, step_p.line, step_p.col);
              mode_d = ModeIdle;
            end else begin
              if (len_q == '0) lead_d = b;
              if (len_q != '1) len_d = len_q + LENGTH_BITS'(1);
            end
          end
          default: begin
            mode_d = i_mode;
            win_d  = i_win;
            len_d  = i_len;
            lead_d = i_lead;
            pos_d  = step_p;
            mv     = i_emit;
            mrec   = i_rec;
          end
        endcase
      end
    end
  end

  always_comb begin
    res_o = '0;
    if (fv && mv) begin
      res_o.count              = 2'd2;
      res_o.first              = frec;
      res_o.second             = mrec;
      res_o.second.last_of_run = 1'b1;
    end else if (fv || mv) begin
      res_o.count             = 2'd1;
      res_o.first             = fv ? frec : mrec;
      res_o.first.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      win_q  <= '0;
      len_q  <= '0;
      lead_q <= '0;
      pos_q  <= '{line: 24'd1, col: 16'd1};
    end else begin
      mode_q <= mode_d;
      win_q  <= win_d;
      len_q  <= len_d;
      lead_q <= lead_d;
      pos_q  <= pos_d;
    end
  end

endmodule
